// File: rtl/core/pps_pkg.sv
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Shared types, codes and default sizes for the scheduler core.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int MAX_TASKS_DEF     = 8;
    localparam int BURST_BITS_DEF    = 12;
    localparam int PRIORITY_BITS_DEF = 4;

    localparam int ID_W     = 8;
    localparam int TIME_W   = 16;
    localparam int STATUS_W = 3;

    localparam logic MODE_ADMIT = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADMIT,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_RUN
    } state_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ADMITTED   = 3'd0,
        STAT_FULL       = 3'd1,
        STAT_ZERO_BURST = 3'd2,
        STAT_IDLE_TICK  = 3'd3,
        STAT_RAN        = 3'd4,
        STAT_DONE       = 3'd5
    } status_t;

endpackage

// File: rtl/core/preemptive_priority_scheduler.sv
// An admit ends at once on a zero burst, else walks the task table from slot 0 to
// the first free or the last slot; a tick scans every slot via the single registered
// read port, then runs the best task. Items wait until the current result is written.
// A new item is taken while the previous result still waits in the output register.
// Reset clears the valid bits, the time counter and all control state; the
// task table itself is not cleared.
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Admits tasks into a small table and, on each tick, runs the ready task with
// the lowest priority number for one unit, reporting completion statistics.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
    parameter int MAX_TASKS     = pps_pkg::MAX_TASKS_DEF,
    parameter int BURST_BITS    = pps_pkg::BURST_BITS_DEF,
    parameter int PRIORITY_BITS = pps_pkg::PRIORITY_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          mode,
    input  logic [pps_pkg::ID_W-1:0]      task_id,
    input  logic [PRIORITY_BITS-1:0]      task_priority,
    input  logic [BURST_BITS-1:0]         burst_length,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [pps_pkg::STATUS_W-1:0]  status,
    output logic [pps_pkg::ID_W-1:0]      running_id,
    output logic [BURST_BITS-1:0]         remaining_burst,
    output logic [pps_pkg::TIME_W-1:0]    turnaround_ticks,
    output logic [pps_pkg::TIME_W-1:0]    waiting_time,
    output logic [pps_pkg::TIME_W-1:0]    current_time
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);
    localparam int ID_W   = pps_pkg::ID_W;
    localparam int TIME_W = pps_pkg::TIME_W;

    pps_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic [ID_W-1:0]          item_id_reg, item_id_next;
    logic [PRIORITY_BITS-1:0] item_prio_reg, item_prio_next;
    logic [BURST_BITS-1:0]    item_burst_reg, item_burst_next;

    logic [MAX_TASKS-1:0] valid_reg, valid_next;
    logic [TIME_W-1:0]    time_reg, time_next;

    logic [ID_W-1:0]          mem_id   [MAX_TASKS];
    logic [PRIORITY_BITS-1:0] mem_prio [MAX_TASKS];
    logic [TIME_W-1:0]        mem_arr  [MAX_TASKS];
    logic [BURST_BITS-1:0]    mem_orig [MAX_TASKS];
    logic [BURST_BITS-1:0]    mem_rem  [MAX_TASKS];

    logic [ID_W-1:0]          rd_id_reg;
    logic [PRIORITY_BITS-1:0] rd_prio_reg;
    logic [TIME_W-1:0]        rd_arr_reg;
    logic [BURST_BITS-1:0]    rd_orig_reg;
    logic [BURST_BITS-1:0]    rd_rem_reg;

    logic             wr_all_en;
    logic             wr_rem_en;
    logic [IDX_W-1:0] wr_addr;
    logic [BURST_BITS-1:0] wr_rem_data;

    logic             cand_en_reg, cand_en_next;
    logic             cand_valid_reg, cand_valid_next;
    logic [IDX_W-1:0] cand_slot_reg, cand_slot_next;

    logic                     best_found_reg, best_found_next;
    logic [IDX_W-1:0]         best_slot_reg, best_slot_next;
    logic [ID_W-1:0]          best_id_reg, best_id_next;
    logic [PRIORITY_BITS-1:0] best_prio_reg, best_prio_next;
    logic [TIME_W-1:0]        best_arr_reg, best_arr_next;
    logic [BURST_BITS-1:0]    best_orig_reg, best_orig_next;
    logic [BURST_BITS-1:0]    best_rem_reg, best_rem_next;
    logic [TIME_W-1:0]        best_age_reg, best_age_next;

    logic                  res_valid_reg, res_valid_next;
    pps_pkg::status_t      res_status_reg, res_status_next;
    logic [ID_W-1:0]       res_id_reg, res_id_next;
    logic [BURST_BITS-1:0] res_rem_reg, res_rem_next;
    logic [TIME_W-1:0]     res_tat_reg, res_tat_next;
    logic [TIME_W-1:0]     res_wt_reg, res_wt_next;
    logic [TIME_W-1:0]     res_time_reg, res_time_next;

    logic                  out_free;
    logic                  accept;
    logic [TIME_W-1:0]     cand_age;
    logic                  take;
    logic [TIME_W-1:0]     time_inc;
    logic [BURST_BITS-1:0] new_rem;
    logic [31:0]           orig_wide;
    logic [TIME_W-1:0]     tat;

    assign out_free  = !res_valid_reg || result_ready;
    assign cand_age  = time_reg - rd_arr_reg;
    assign take      = cand_en_reg && cand_valid_reg &&
                       (!best_found_reg || (rd_prio_reg < best_prio_reg) ||
                        ((rd_prio_reg == best_prio_reg) && (cand_age > best_age_reg)));
    assign time_inc  = time_reg + TIME_W'(1);
    assign new_rem   = best_rem_reg - BURST_BITS'(1);
    assign orig_wide = 32'(best_orig_reg);
    assign tat       = time_inc - best_arr_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pps_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = (mode == pps_pkg::MODE_TICK) ? pps_pkg::ST_SCAN
                                                              : pps_pkg::ST_ADMIT;
                end
            end
            pps_pkg::ST_ADMIT:
            begin
                if (out_free && ((item_burst_reg == '0) || !valid_reg[idx_reg] ||
                                 (idx_reg == LAST_IDX)))
                begin
                    state_next = pps_pkg::ST_IDLE;
                end
            end
            pps_pkg::ST_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = pps_pkg::ST_SCAN_LAST;
                end
            end
            pps_pkg::ST_SCAN_LAST:
            begin
                state_next = pps_pkg::ST_RUN;
            end
            pps_pkg::ST_RUN:
            begin
                if (out_free)
                begin
                    state_next = pps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready      = (state_reg == pps_pkg::ST_IDLE);
        accept          = item_valid && item_ready;
        idx_next        = idx_reg;
        item_id_next    = item_id_reg;
        item_prio_next  = item_prio_reg;
        item_burst_next = item_burst_reg;
        valid_next      = valid_reg;
        time_next       = time_reg;
        wr_all_en       = 1'b0;
        wr_rem_en       = 1'b0;
        wr_addr         = idx_reg;
        wr_rem_data     = new_rem;
        cand_en_next    = 1'b0;
        cand_valid_next = cand_valid_reg;
        cand_slot_next  = cand_slot_reg;
        best_found_next = best_found_reg;
        best_slot_next  = best_slot_reg;
        best_id_next    = best_id_reg;
        best_prio_next  = best_prio_reg;
        best_arr_next   = best_arr_reg;
        best_orig_next  = best_orig_reg;
        best_rem_next   = best_rem_reg;
        best_age_next   = best_age_reg;
        res_valid_next  = res_valid_reg && !result_ready;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_rem_next    = res_rem_reg;
        res_tat_next    = res_tat_reg;
        res_wt_next     = res_wt_reg;
        res_time_next   = res_time_reg;

        if (take)
        begin
            best_found_next = 1'b1;
            best_slot_next  = cand_slot_reg;
            best_id_next    = rd_id_reg;
            best_prio_next  = rd_prio_reg;
            best_arr_next   = rd_arr_reg;
            best_orig_next  = rd_orig_reg;
            best_rem_next   = rd_rem_reg;
            best_age_next   = cand_age;
        end

        case (state_reg)
            pps_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    item_id_next    = task_id;
                    item_prio_next  = task_priority;
                    item_burst_next = burst_length;
                    idx_next        = '0;
                    best_found_next = 1'b0;
                end
            end
            pps_pkg::ST_ADMIT:
            begin
                if (out_free)
                begin
                    res_id_next   = '0;
                    res_rem_next  = '0;
                    res_tat_next  = '0;
                    res_wt_next   = '0;
                    res_time_next = time_reg;
                    if (item_burst_reg == '0)
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = pps_pkg::STAT_ZERO_BURST;
                    end
                    else if (!valid_reg[idx_reg])
                    begin
                        wr_all_en           = 1'b1;
                        valid_next[idx_reg] = 1'b1;
                        res_valid_next      = 1'b1;
                        res_status_next     = pps_pkg::STAT_ADMITTED;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = pps_pkg::STAT_FULL;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            pps_pkg::ST_SCAN:
            begin
                cand_en_next    = 1'b1;
                cand_valid_next = valid_reg[idx_reg];
                cand_slot_next  = idx_reg;
                if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            pps_pkg::ST_SCAN_LAST:
            begin
                cand_en_next = 1'b0;
            end
            pps_pkg::ST_RUN:
            begin
                if (out_free)
                begin
                    time_next      = time_inc;
                    res_valid_next = 1'b1;
                    res_time_next  = time_inc;
                    res_tat_next   = '0;
                    res_wt_next    = '0;
                    if (!best_found_reg)
                    begin
                        res_status_next = pps_pkg::STAT_IDLE_TICK;
                        res_id_next     = '0;
                        res_rem_next    = '0;
                    end
                    else
                    begin
                        wr_rem_en    = 1'b1;
                        wr_addr      = best_slot_reg;
                        res_id_next  = best_id_reg;
                        res_rem_next = new_rem;
                        if (new_rem == '0)
                        begin
                            valid_next[best_slot_reg] = 1'b0;
                            res_status_next = pps_pkg::STAT_DONE;
                            res_tat_next    = tat;
                            res_wt_next     = tat - orig_wide[TIME_W-1:0];
                        end
                        else
                        begin
                            res_status_next = pps_pkg::STAT_RAN;
                        end
                    end
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pps_pkg::ST_IDLE;
            idx_reg        <= '0;
            valid_reg      <= '0;
            time_reg       <= '0;
            cand_en_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            valid_reg      <= valid_next;
            time_reg       <= time_next;
            cand_en_reg    <= cand_en_next;
            best_found_reg <= best_found_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_id_reg     <= item_id_next;
        item_prio_reg   <= item_prio_next;
        item_burst_reg  <= item_burst_next;
        cand_valid_reg  <= cand_valid_next;
        cand_slot_reg   <= cand_slot_next;
        best_slot_reg   <= best_slot_next;
        best_id_reg     <= best_id_next;
        best_prio_reg   <= best_prio_next;
        best_arr_reg    <= best_arr_next;
        best_orig_reg   <= best_orig_next;
        best_rem_reg    <= best_rem_next;
        best_age_reg    <= best_age_next;
        res_status_reg  <= res_status_next;
        res_id_reg      <= res_id_next;
        res_rem_reg     <= res_rem_next;
        res_tat_reg     <= res_tat_next;
        res_wt_reg      <= res_wt_next;
        res_time_reg    <= res_time_next;
    end

    // The task table: one write port, one registered read port driven by the scan index.
    always_ff @(posedge clk)
    begin
        if (wr_all_en)
        begin
            mem_id[wr_addr]   <= item_id_reg;
            mem_prio[wr_addr] <= item_prio_reg;
            mem_arr[wr_addr]  <= time_reg;
            mem_orig[wr_addr] <= item_burst_reg;
            mem_rem[wr_addr]  <= item_burst_reg;
        end
        else if (wr_rem_en)
        begin
            mem_rem[wr_addr] <= wr_rem_data;
        end
        rd_id_reg   <= mem_id[idx_reg];
        rd_prio_reg <= mem_prio[idx_reg];
        rd_arr_reg  <= mem_arr[idx_reg];
        rd_orig_reg <= mem_orig[idx_reg];
        rd_rem_reg  <= mem_rem[idx_reg];
    end

    assign result_valid     = res_valid_reg;
    assign status           = res_status_reg;
    assign running_id       = res_id_reg;
    assign remaining_burst  = res_rem_reg;
    assign turnaround_ticks = res_tat_reg;
    assign waiting_time     = res_wt_reg;
    assign current_time     = res_time_reg;

    // Time moves only when a tick completes.
    a_time_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pps_pkg::ST_RUN && out_free) |=> (time_reg == $past(time_inc)))
        else $error("Time counter did not advance on a completed tick.");

    a_time_on_admit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pps_pkg::ST_ADMIT) |=> (time_reg == $past(time_reg)))
        else $error("Time counter changed during an admit.");

    a_completion_frees_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pps_pkg::ST_RUN && out_free && best_found_reg &&
         best_rem_reg == BURST_BITS'(1))
        |=> ($countones(valid_reg) + 1 == $countones($past(valid_reg))))
        else $error("A completed task did not leave the table.");

    a_admit_fills_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_all_en) |=> ($countones(valid_reg) == $countones($past(valid_reg)) + 1))
        else $error("An admitted task did not occupy a free slot.");

endmodule
